FILE: sv/dlbpc_pkg.sv
package dlbpc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned ACT_W = 4;
  localparam int unsigned SEL_W = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned STEP_SEGS = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK       = 4'd0,
    ACT_WIFI_CONN  = 4'd1,
    ACT_WIFI_DONE  = 4'd2,
    ACT_CHG_START  = 4'd3,
    ACT_CHG_STOP   = 4'd4,
    ACT_EYE_ON     = 4'd5,
    ACT_EYE_OFF    = 4'd6,
    ACT_EYE_BLINK  = 4'd7,
    ACT_EAR_ON     = 4'd8,
    ACT_EAR_OFF    = 4'd9,
    ACT_EAR_BLINK  = 4'd10
  } action_t;

  localparam logic [SEL_W-1:0] PAT_300   = 3'd0;
  localparam logic [SEL_W-1:0] PAT_500   = 3'd1;
  localparam logic [SEL_W-1:0] PAT_800   = 3'd2;
  localparam logic [SEL_W-1:0] PAT_1000  = 3'd3;
  localparam logic [SEL_W-1:0] PAT_3000  = 3'd4;
  localparam logic [SEL_W-1:0] PAT_STEP  = 3'd5;

  localparam logic [STAT_W-1:0] ST_UNSET = 2'd0;
  localparam logic [STAT_W-1:0] ST_ON    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OFF   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BLINK = 2'd3;

  localparam logic [TIME_W-1:0] STEP_END [STEP_SEGS] = '{
    32'd1500, 32'd3000, 32'd4500, 32'd7500, 32'd9000, 32'd17000
  };

  // blink timer state for one lamp
  typedef struct packed {
    logic              lamp;
    logic              restart;
    logic [TIME_W-1:0] start;
  } tmr_t;

  function automatic logic [TIME_W-1:0] half_ms(input logic [SEL_W-1:0] sel);
    logic [TIME_W-1:0] h;
    case (sel)
      PAT_300:  h = 32'd300;
      PAT_500:  h = 32'd500;
      PAT_800:  h = 32'd800;
      PAT_1000: h = 32'd1000;
      PAT_3000: h = 32'd3000;
      default:  h = 32'd0;
    endcase
    return h;
  endfunction

endpackage

FILE: sv/dlbpc_timer.sv
module dlbpc_timer (
  input  logic [dlbpc_pkg::SEL_W-1:0]  pattern,
  input  logic [dlbpc_pkg::TIME_W-1:0] now_ms,
  input  dlbpc_pkg::tmr_t              cur,
  output dlbpc_pkg::tmr_t              nxt
);

  logic [dlbpc_pkg::TIME_W-1:0] start_eff;
  logic [dlbpc_pkg::TIME_W-1:0] elapsed;
  logic [dlbpc_pkg::TIME_W-1:0] half;
  logic [dlbpc_pkg::TIME_W:0]   full;
  logic                         found;

  assign start_eff = cur.restart ? now_ms : cur.start;
  assign elapsed   = now_ms - start_eff;
  assign half      = dlbpc_pkg::half_ms(pattern);
  assign full      = {half, 1'b0};

  always_comb begin
    nxt       = cur;
    nxt.start = start_eff;
    found     = 1'b0;
    if (pattern == dlbpc_pkg::PAT_STEP) begin
      for (int i = 0; i < dlbpc_pkg::STEP_SEGS; i++) begin
        if (!found && elapsed < dlbpc_pkg::STEP_END[i]) begin
          found    = 1'b1;
          nxt.lamp = (i % 2 == 0);
          if (i == 0) begin
            nxt.restart = 1'b0;
          end
        end
      end
      if (!found) begin
        nxt.restart = 1'b1;
        nxt.lamp    = 1'b1;
      end
    end else if (pattern < dlbpc_pkg::PAT_STEP) begin
      if (elapsed < half) begin
        nxt.restart = 1'b0;
        nxt.lamp    = 1'b1;
      end else if ({1'b0, elapsed} < full) begin
        nxt.lamp = 1'b0;
      end else begin
        nxt.restart = 1'b1;
        nxt.lamp    = 1'b1;
      end
    end else begin
      nxt = cur;
    end
  end

endmodule

FILE: sv/dual_led_blink_pattern_controller.sv
// A request passes an input register and then a result register.
// Throughput: one request per cycle; in_tready drops only while both stages hold
// a request and out_tready is low.
// Reset (rst_n low, synchronous): both stages empty, lamps off, modes unset,
// blink off, both phase restart flags set.
module dual_led_blink_pattern_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dlbpc_pkg::IN_DATA_W-1:0]      in_tdata,   // eye_pattern_sel[2:0], now_ms[34:3]
  input  logic [dlbpc_pkg::ACT_W-1:0]          in_tuser,   // action[3:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dlbpc_pkg::OUT_DATA_W-1:0]     out_tdata   // eye_lamp[0], ear_lamp[1],
                                                           // eye_status[3:2], ear_status[5:4]
);

  logic                           in_valid_r;
  logic [dlbpc_pkg::ACT_W-1:0]    act_r;
  logic [dlbpc_pkg::SEL_W-1:0]    sel_r;
  logic [dlbpc_pkg::TIME_W-1:0]   now_r;
  logic                           out_valid_r;
  logic [dlbpc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                           advance;

  logic                           eye_blinking_r, eye_blinking_nxt;
  logic [dlbpc_pkg::SEL_W-1:0]    eye_pattern_r, eye_pattern_nxt;
  dlbpc_pkg::tmr_t                eye_tmr_r, eye_tmr_nxt, eye_tmr_run;
  logic                           ear_blinking_r, ear_blinking_nxt;
  dlbpc_pkg::tmr_t                ear_tmr_r, ear_tmr_nxt, ear_tmr_run;
  logic                           charging_r, charging_nxt;
  logic [dlbpc_pkg::STAT_W-1:0]   eye_status_r, eye_status_nxt;
  logic [dlbpc_pkg::STAT_W-1:0]   ear_status_r, ear_status_nxt;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  dlbpc_timer u_eye_tmr (
    .pattern (eye_pattern_r),
    .now_ms  (now_r),
    .cur     (eye_tmr_r),
    .nxt     (eye_tmr_run)
  );

  dlbpc_timer u_ear_tmr (
    .pattern (dlbpc_pkg::PAT_500),
    .now_ms  (now_r),
    .cur     (ear_tmr_r),
    .nxt     (ear_tmr_run)
  );

  always_comb begin
    eye_blinking_nxt = eye_blinking_r;
    eye_pattern_nxt  = eye_pattern_r;
    eye_tmr_nxt      = eye_tmr_r;
    ear_blinking_nxt = ear_blinking_r;
    ear_tmr_nxt      = ear_tmr_r;
    charging_nxt     = charging_r;
    eye_status_nxt   = eye_status_r;
    ear_status_nxt   = ear_status_r;
    case (act_r)
      dlbpc_pkg::ACT_TICK: begin
        if (eye_blinking_r) begin
          eye_tmr_nxt = eye_tmr_run;
        end
        if (ear_blinking_r) begin
          ear_tmr_nxt = ear_tmr_run;
        end
      end
      dlbpc_pkg::ACT_WIFI_CONN: begin
        eye_blinking_nxt = 1'b1;
        eye_pattern_nxt  = dlbpc_pkg::PAT_STEP;
        eye_status_nxt   = dlbpc_pkg::ST_ON;
        ear_blinking_nxt = 1'b1;
        ear_status_nxt   = dlbpc_pkg::ST_BLINK;
      end
      dlbpc_pkg::ACT_WIFI_DONE: begin
        if (charging_r) begin
          eye_blinking_nxt = 1'b0;
          eye_tmr_nxt.lamp = 1'b0;
          eye_status_nxt   = dlbpc_pkg::ST_OFF;
          ear_blinking_nxt = 1'b0;
          ear_tmr_nxt.lamp = 1'b0;
          ear_status_nxt   = dlbpc_pkg::ST_OFF;
        end else begin
          eye_blinking_nxt = 1'b1;
          eye_pattern_nxt  = dlbpc_pkg::PAT_STEP;
          eye_status_nxt   = dlbpc_pkg::ST_ON;
          ear_blinking_nxt = 1'b0;
          ear_tmr_nxt.lamp = 1'b1;
          ear_status_nxt   = dlbpc_pkg::ST_ON;
        end
      end
      dlbpc_pkg::ACT_CHG_START: charging_nxt = 1'b1;
      dlbpc_pkg::ACT_CHG_STOP:  charging_nxt = 1'b0;
      dlbpc_pkg::ACT_EYE_ON: begin
        eye_blinking_nxt = 1'b0;
        eye_tmr_nxt.lamp = 1'b1;
        eye_status_nxt   = dlbpc_pkg::ST_ON;
      end
      dlbpc_pkg::ACT_EYE_OFF: begin
        eye_blinking_nxt = 1'b0;
        eye_tmr_nxt.lamp = 1'b0;
        eye_status_nxt   = dlbpc_pkg::ST_OFF;
      end
      dlbpc_pkg::ACT_EYE_BLINK: begin
        if (sel_r <= dlbpc_pkg::PAT_STEP) begin
          eye_blinking_nxt = 1'b1;
          eye_pattern_nxt  = sel_r;
          eye_status_nxt   = dlbpc_pkg::ST_ON;
        end
      end
      dlbpc_pkg::ACT_EAR_ON: begin
        ear_blinking_nxt = 1'b0;
        ear_tmr_nxt.lamp = 1'b1;
        ear_status_nxt   = dlbpc_pkg::ST_ON;
      end
      dlbpc_pkg::ACT_EAR_OFF: begin
        ear_blinking_nxt = 1'b0;
        ear_tmr_nxt.lamp = 1'b0;
        ear_status_nxt   = dlbpc_pkg::ST_OFF;
      end
      dlbpc_pkg::ACT_EAR_BLINK: begin
        ear_blinking_nxt = 1'b1;
        ear_status_nxt   = dlbpc_pkg::ST_BLINK;
      end
      default: ;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      act_r <= in_tuser;
      sel_r <= in_tdata[dlbpc_pkg::SEL_W-1:0];
      now_r <= in_tdata[dlbpc_pkg::SEL_W +: dlbpc_pkg::TIME_W];
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      eye_blinking_r    <= 1'b0;
      eye_pattern_r     <= dlbpc_pkg::PAT_300;
      eye_tmr_r.lamp    <= 1'b0;
      eye_tmr_r.restart <= 1'b1;
      eye_tmr_r.start   <= '0;
      ear_blinking_r    <= 1'b0;
      ear_tmr_r.lamp    <= 1'b0;
      ear_tmr_r.restart <= 1'b1;
      ear_tmr_r.start   <= '0;
      charging_r        <= 1'b0;
      eye_status_r      <= dlbpc_pkg::ST_UNSET;
      ear_status_r      <= dlbpc_pkg::ST_UNSET;
    end else begin
      if (out_tready || !out_valid_r) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        eye_blinking_r <= eye_blinking_nxt;
        eye_pattern_r  <= eye_pattern_nxt;
        eye_tmr_r      <= eye_tmr_nxt;
        ear_blinking_r <= ear_blinking_nxt;
        ear_tmr_r      <= ear_tmr_nxt;
        charging_r     <= charging_nxt;
        eye_status_r   <= eye_status_nxt;
        ear_status_r   <= ear_status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, ear_status_nxt, eye_status_nxt,
                     ear_tmr_nxt.lamp, eye_tmr_nxt.lamp};
    end
  end

endmodule
